// ===== hw/rtl/sfag_pkg.sv =====
// sfag_pkg: constants, register codes and types for the segmented frame address generator
// no dependencies; imported by segmented_frame_address_generator
`timescale 1ns / 1ps

package sfag_pkg;

    localparam int MAX_DIMENSION = 4096;
    localparam int MAX_SEGMENTS  = 64;
    localparam int ADDRESS_WIDTH = 32;

    localparam int DIM_W      = 13;
    localparam int SEGCFG_W   = 7;
    localparam int DIR_W      = 2;
    localparam int COORD_W    = 12;
    localparam int SEGCNT_W   = 6;
    localparam int SEGNUM_W   = 12;
    localparam int IDX_W      = 24;
    localparam int AREA_W     = 2 * DIM_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int DIV_STEPS  = DIM_W;
    localparam int DIV_CNT_W  = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH     = 3'd0,
        REG_IMAGE_HEIGHT    = 3'd1,
        REG_SEGMENTS_ACROSS = 3'd2,
        REG_SEGMENTS_DOWN   = 3'd3,
        REG_READ_DIRECTION  = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        CS_READY,
        CS_DIVIDE
    } cfg_state_t;

    typedef struct packed {
        logic [COORD_W-1:0]       row;
        logic [COORD_W-1:0]       col;
        logic [SEGNUM_W-1:0]      segment_number;
        logic                     last_in_row;
        logic                     last_in_segment;
        logic                     last_in_frame;
        logic                     config_error;
        logic [ADDRESS_WIDTH-1:0] frame_base;
    } px_stage_t;

endpackage

// ===== hw/rtl/segmented_frame_address_generator.sv =====
// segmented_frame_address_generator: segment-ordered pixel address generator
// depends on sfag_pkg (constants, register codes, stage types)
`timescale 1ns / 1ps

// channel  dir  handshake          payload
// s_       in   s_valid/s_ready    s_restart
// m_       out  m_valid/m_ready    m_frame_address .. m_config_error
// cfg_     in   cfg_wr_en          cfg_index, cfg_data
//
// one beat per cycle sustained while s_ready is high; a beat reaches m_ through
// three register stages: position, pixel index multiply, frame base add
// after reset and after every register write the segment sizes come from a
// serial divider: s_ready stays low while it runs
// the three stages stall together when m_valid is high and m_ready is low
// reset is synchronous on aresetn low; control registers reset, pipeline data does not

module segmented_frame_address_generator
    import sfag_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_restart,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [ADDRESS_WIDTH-1:0] m_frame_address,
    output logic [IDX_W-1:0]         m_pixel_index,
    output logic [COORD_W-1:0]       m_pixel_row,
    output logic [COORD_W-1:0]       m_pixel_col,
    output logic [SEGNUM_W-1:0]      m_segment_number,
    output logic                     m_last_in_row,
    output logic                     m_last_in_segment,
    output logic                     m_last_in_frame,
    output logic                     m_config_error
);

    // configuration registers
    logic [DIM_W-1:0]    image_width_reg;
    logic [DIM_W-1:0]    image_height_reg;
    logic [SEGCFG_W-1:0] segments_across_reg;
    logic [SEGCFG_W-1:0] segments_down_reg;
    logic [DIR_W-1:0]    read_direction_reg;

    // divider
    cfg_state_t          cfg_state_reg, cfg_state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [SEGCFG_W-1:0] rem_w_reg, rem_h_reg;
    logic [DIM_W-1:0]    seg_w_reg, seg_h_reg;
    logic [DIV_CNT_W-1:0] div_bit;
    logic [SEGCFG_W:0]   shift_w, shift_h;
    logic                ge_w, ge_h;
    logic                div_busy;
    logic [AREA_W-1:0]   area_reg;

    // walk state
    logic [COORD_W-1:0]       column_step_reg, column_step_next;
    logic [COORD_W-1:0]       row_step_reg, row_step_next;
    logic [SEGCNT_W-1:0]      segment_col_reg, segment_col_next;
    logic [SEGCNT_W-1:0]      segment_row_reg, segment_row_next;
    logic [ADDRESS_WIDTH-1:0] frame_base_reg, frame_base_next;

    // pipeline
    logic                v1_reg, v2_reg, v3_reg;
    px_stage_t           st1_reg, st1_next, st2_reg;
    logic [IDX_W-1:0]    idx2_reg;
    logic                advance, accept;

    logic                cfg_bad;
    logic [COORD_W-1:0]  cs_r, rs_r;
    logic [SEGCNT_W-1:0] sc_r, sr_r;
    logic [ADDRESS_WIDTH-1:0] fb_r;
    logic [COORD_W-1:0]  cs_n, rs_n;
    logic [SEGCNT_W-1:0] sc_n, sr_n;
    logic [DIM_W-1:0]    col_off, row_off, col_full, row_full;
    logic [DIM_W-1:0]    cs_ext, rs_ext;
    logic                end_row, end_seg, end_seg_row, end_frame;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg     <= DIM_W'(640);
            image_height_reg    <= DIM_W'(480);
            segments_across_reg <= SEGCFG_W'(1);
            segments_down_reg   <= SEGCFG_W'(1);
            read_direction_reg  <= DIR_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:     image_width_reg     <= cfg_data;
                REG_IMAGE_HEIGHT:    image_height_reg    <= cfg_data;
                REG_SEGMENTS_ACROSS: segments_across_reg <= cfg_data[SEGCFG_W-1:0];
                REG_SEGMENTS_DOWN:   segments_down_reg   <= cfg_data[SEGCFG_W-1:0];
                REG_READ_DIRECTION:  read_direction_reg  <= cfg_data[DIR_W-1:0];
                default: ;
            endcase
        end
    end

    // restoring division, one quotient bit per cycle
    assign div_bit = DIV_CNT_W'(DIV_STEPS - 1) - div_cnt_reg;
    assign shift_w = {rem_w_reg, image_width_reg[div_bit]};
    assign shift_h = {rem_h_reg, image_height_reg[div_bit]};
    assign ge_w    = (shift_w >= {1'b0, segments_across_reg});
    assign ge_h    = (shift_h >= {1'b0, segments_down_reg});

    always_comb begin
        cfg_state_next = cfg_state_reg;
        if (cfg_wr_en) begin
            cfg_state_next = CS_DIVIDE;
        end else begin
            unique case (cfg_state_reg)
                CS_READY:  cfg_state_next = CS_READY;
                CS_DIVIDE: begin
                    if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                        cfg_state_next = CS_READY;
                    end
                end
                default:   cfg_state_next = CS_DIVIDE;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_state_reg)
            CS_READY:  div_busy = 1'b0;
            CS_DIVIDE: div_busy = 1'b1;
            default:   div_busy = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_state_reg <= CS_DIVIDE;
            div_cnt_reg   <= '0;
            rem_w_reg     <= '0;
            rem_h_reg     <= '0;
            seg_w_reg     <= '0;
            seg_h_reg     <= '0;
        end else begin
            cfg_state_reg <= cfg_state_next;
            if (cfg_wr_en) begin
                div_cnt_reg <= '0;
                rem_w_reg   <= '0;
                rem_h_reg   <= '0;
                seg_w_reg   <= '0;
                seg_h_reg   <= '0;
            end else if (div_busy) begin
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                rem_w_reg   <= ge_w ? SEGCFG_W'(shift_w - {1'b0, segments_across_reg})
                                    : SEGCFG_W'(shift_w);
                rem_h_reg   <= ge_h ? SEGCFG_W'(shift_h - {1'b0, segments_down_reg})
                                    : SEGCFG_W'(shift_h);
                seg_w_reg   <= {seg_w_reg[DIM_W-2:0], ge_w};
                seg_h_reg   <= {seg_h_reg[DIM_W-2:0], ge_h};
            end
        end
    end

    always_ff @(posedge aclk) begin
        area_reg <= AREA_W'(image_width_reg) * AREA_W'(image_height_reg);
    end

    assign cfg_bad = (image_width_reg == '0) || (image_width_reg > DIM_W'(MAX_DIMENSION))
                  || (image_height_reg == '0) || (image_height_reg > DIM_W'(MAX_DIMENSION))
                  || (segments_across_reg == '0)
                  || (segments_across_reg > SEGCFG_W'(MAX_SEGMENTS))
                  || (segments_down_reg == '0)
                  || (segments_down_reg > SEGCFG_W'(MAX_SEGMENTS))
                  || (rem_w_reg != '0) || (rem_h_reg != '0);

    // handshake
    assign advance = !v3_reg || m_ready;
    assign s_ready = !div_busy && advance;
    assign accept  = s_valid && s_ready;

    // stage one: position within the frame and the next walk state
    always_comb begin
        cs_r = s_restart ? '0 : column_step_reg;
        rs_r = s_restart ? '0 : row_step_reg;
        sc_r = s_restart ? '0 : segment_col_reg;
        sr_r = s_restart ? '0 : segment_row_reg;
        fb_r = s_restart ? '0 : frame_base_reg;

        // stale counters fold back to zero
        cs_n = ({1'b0, cs_r} >= seg_w_reg) ? '0 : cs_r;
        rs_n = ({1'b0, rs_r} >= seg_h_reg) ? '0 : rs_r;
        sc_n = ({1'b0, sc_r} >= segments_across_reg) ? '0 : sc_r;
        sr_n = ({1'b0, sr_r} >= segments_down_reg) ? '0 : sr_r;

        cs_ext  = {1'b0, cs_n};
        rs_ext  = {1'b0, rs_n};
        col_off = read_direction_reg[0] ? cs_ext : (seg_w_reg - DIM_W'(1) - cs_ext);
        row_off = read_direction_reg[1] ? (seg_h_reg - DIM_W'(1) - rs_ext) : rs_ext;
        col_full = DIM_W'(sc_n) * seg_w_reg + col_off;
        row_full = DIM_W'(sr_n) * seg_h_reg + row_off;

        end_row     = (cs_ext + DIM_W'(1) == seg_w_reg);
        end_seg     = end_row && (rs_ext + DIM_W'(1) == seg_h_reg);
        end_seg_row = end_seg && ({1'b0, sc_n} + SEGCFG_W'(1) == segments_across_reg);
        end_frame   = end_seg_row && ({1'b0, sr_n} + SEGCFG_W'(1) == segments_down_reg);

        st1_next = '0;
        column_step_next = cs_r;
        row_step_next    = rs_r;
        segment_col_next = sc_r;
        segment_row_next = sr_r;
        frame_base_next  = fb_r;

        if (cfg_bad) begin
            st1_next.config_error = 1'b1;
        end else begin
            st1_next.row             = row_full[COORD_W-1:0];
            st1_next.col             = col_full[COORD_W-1:0];
            st1_next.segment_number  = SEGNUM_W'(sr_n) * SEGNUM_W'(segments_across_reg)
                                     + SEGNUM_W'(sc_n);
            st1_next.last_in_row     = end_row;
            st1_next.last_in_segment = end_seg;
            st1_next.last_in_frame   = end_frame;
            st1_next.frame_base      = fb_r;

            column_step_next = end_row ? '0 : cs_n + COORD_W'(1);
            row_step_next    = end_seg ? '0 : (end_row ? rs_n + COORD_W'(1) : rs_n);
            segment_col_next = end_seg_row ? '0 : (end_seg ? sc_n + SEGCNT_W'(1) : sc_n);
            segment_row_next = end_frame ? '0 : (end_seg_row ? sr_n + SEGCNT_W'(1) : sr_n);
            frame_base_next  = end_frame ? fb_r + ADDRESS_WIDTH'(area_reg) : fb_r;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_step_reg <= '0;
            row_step_reg    <= '0;
            segment_col_reg <= '0;
            segment_row_reg <= '0;
            frame_base_reg  <= '0;
        end else if (accept) begin
            column_step_reg <= column_step_next;
            row_step_reg    <= row_step_next;
            segment_col_reg <= segment_col_next;
            segment_row_reg <= segment_row_next;
            frame_base_reg  <= frame_base_next;
        end
    end

    // pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage two: pixel index; stage three: frame address
    always_ff @(posedge aclk) begin
        if (advance) begin
            st1_reg  <= st1_next;
            st2_reg  <= st1_reg;
            idx2_reg <= IDX_W'(st1_reg.row) * IDX_W'(image_width_reg) + IDX_W'(st1_reg.col);

            m_frame_address   <= st2_reg.frame_base + ADDRESS_WIDTH'(idx2_reg);
            m_pixel_index     <= idx2_reg;
            m_pixel_row       <= st2_reg.row;
            m_pixel_col       <= st2_reg.col;
            m_segment_number  <= st2_reg.segment_number;
            m_last_in_row     <= st2_reg.last_in_row;
            m_last_in_segment <= st2_reg.last_in_segment;
            m_last_in_frame   <= st2_reg.last_in_frame;
            m_config_error    <= st2_reg.config_error;
        end
    end

    assign m_valid = v3_reg;

endmodule
